// ===== design/qrk_pkg.sv =====
// ---------------------------------------------------------------------------
// qrk_pkg: shared types, constants and round functions
// Feedback and output functions of the 136-bit permutation, plus the
// control types that pass between the top level and the round core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qrk_pkg;

	localparam int HALF_BITS   = 68;
	localparam int LFSR_BITS   = 10;
	localparam int ROUND_COUNT = 544;
	localparam int RND_W       = $clog2(ROUND_COUNT + 1);
	localparam int HEAD_W      = 64;
	localparam int MID_W       = 8;
	localparam int TAIL_W      = 64;
	localparam int NIB_W       = HALF_BITS - HEAD_W;

	typedef logic [HALF_BITS-1:0] half_t;
	typedef logic [LFSR_BITS-1:0] lfsr_t;
	typedef logic [RND_W-1:0]     rnd_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} st_t;

	// top -> core
	typedef struct packed {
		logic load;
	} core_ctrl_t;

	// core -> top
	typedef struct packed {
		logic done;
		logic active;
	} core_stat_t;

	// Registers are held MSB first: stage k sits at vector bit HALF_BITS-1-k.
	function automatic half_t stage_order(input half_t v);
		half_t r;
		for (int k = 0; k < HALF_BITS; k++) begin
			r[k] = v[HALF_BITS-1-k];
		end
		return r;
	endfunction

	// Nonlinear feedback of X (includes the y[0] term)
	function automatic logic fb_x(input half_t xv, input half_t yv);
		half_t x;
		half_t y;
		x = stage_order(xv);
		y = stage_order(yv);
		return x[0] ^ y[0] ^ x[9] ^ x[14] ^ x[21] ^ x[28] ^ x[33] ^ x[37] ^ x[45] ^
			x[52] ^ x[55] ^ x[50] ^
			(x[59] & x[55]) ^ (x[37] & x[33]) ^ (x[15] & x[9]) ^
			(x[55] & x[52] & x[45]) ^ (x[33] & x[28] & x[21]) ^
			(x[59] & x[45] & x[28] & x[9]) ^
			(x[55] & x[52] & x[37] & x[33]) ^
			(x[59] & x[55] & x[21] & x[15]) ^
			(x[59] & x[55] & x[52] & x[45] & x[37]) ^
			(x[33] & x[28] & x[21] & x[15] & x[9]) ^
			(x[52] & x[45] & x[37] & x[33] & x[28] & x[21]);
	endfunction

	// Nonlinear feedback of Y
	function automatic logic fb_y(input half_t yv);
		half_t y;
		y = stage_order(yv);
		return y[0] ^ y[7] ^ y[16] ^ y[20] ^ y[30] ^ y[35] ^ y[37] ^ y[42] ^
			y[51] ^ y[54] ^ y[49] ^
			(y[58] & y[54]) ^ (y[37] & y[35]) ^ (y[15] & y[7]) ^
			(y[54] & y[51] & y[42]) ^ (y[35] & y[30] & y[20]) ^
			(y[58] & y[42] & y[30] & y[7]) ^
			(y[54] & y[51] & y[37] & y[35]) ^
			(y[58] & y[54] & y[20] & y[15]) ^
			(y[58] & y[54] & y[51] & y[42] & y[37]) ^
			(y[35] & y[30] & y[20] & y[15] & y[7]) ^
			(y[51] & y[42] & y[37] & y[35] & y[30] & y[20]);
	endfunction

	// Output function h over X, Y and the LFSR (l[k] at bit k)
	function automatic logic out_h(input half_t xv, input half_t yv, input lfsr_t l);
		half_t x;
		half_t y;
		x = stage_order(xv);
		y = stage_order(yv);
		return x[25] ^ y[59] ^ (y[3] & x[55]) ^ (x[46] & x[55]) ^ (x[55] & y[59]) ^
			(y[3] & x[25] & x[46]) ^ (y[3] & x[46] & x[55]) ^
			(y[3] & x[46] & y[59]) ^ (x[25] & x[46] & y[59] & l[0]) ^
			(x[25] & l[0]) ^
			x[1] ^ y[2] ^ x[4] ^ y[10] ^ x[31] ^ y[43] ^ x[56] ^ l[0];
	endfunction

endpackage

`default_nettype wire

// ===== design/qrk_in_if.sv =====
// ---------------------------------------------------------------------------
// qrk_in_if: input state channel
// Valid/ready channel carrying one 136-bit state per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qrk_in_if;
	logic                         valid;
	logic                         ready;
	logic [qrk_pkg::HEAD_W-1:0]   state_head;
	logic [qrk_pkg::MID_W-1:0]    state_middle;
	logic [qrk_pkg::TAIL_W-1:0]   state_tail;

	modport source (output valid, state_head, state_middle, state_tail, input ready);
	modport sink   (input valid, state_head, state_middle, state_tail, output ready);
endinterface

`default_nettype wire

// ===== design/qrk_out_if.sv =====
// ---------------------------------------------------------------------------
// qrk_out_if: permuted state channel
// Valid/ready channel carrying one permuted 136-bit state per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qrk_out_if;
	logic                         valid;
	logic                         ready;
	logic [qrk_pkg::HEAD_W-1:0]   permuted_head;
	logic [qrk_pkg::MID_W-1:0]    permuted_middle;
	logic [qrk_pkg::TAIL_W-1:0]   permuted_tail;

	modport source (output valid, permuted_head, permuted_middle, permuted_tail, input ready);
	modport sink   (input valid, permuted_head, permuted_middle, permuted_tail, output ready);
endinterface

`default_nettype wire

// ===== design/qrk_core.sv =====
// ---------------------------------------------------------------------------
// qrk_core: round engine
// Two 68-bit feedback shift registers and the 10-bit LFSR; one bit shifts
// into each register per cycle, one round per cycle, counted down.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qrk_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire qrk_pkg::core_ctrl_t  ctrl,
	input  wire qrk_pkg::half_t       x_in,
	input  wire qrk_pkg::half_t       y_in,
	output qrk_pkg::core_stat_t       stat,
	output qrk_pkg::half_t            x_out,
	output qrk_pkg::half_t            y_out
);

	qrk_pkg::half_t x_q;
	qrk_pkg::half_t y_q;
	qrk_pkg::lfsr_t l_q;
	qrk_pkg::rnd_t  cnt_q;
	logic           h;
	logic           nx;
	logic           ny;

	// round feedback
	always_comb begin
		h  = qrk_pkg::out_h(x_q, y_q, l_q);
		nx = qrk_pkg::fb_x(x_q, y_q) ^ h;
		ny = qrk_pkg::fb_y(y_q) ^ h;
	end

	// round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= qrk_pkg::RND_W'(qrk_pkg::ROUND_COUNT);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - qrk_pkg::RND_W'(1);
		end
	end

	// shift registers: stage 0 leaves, feedback enters at the far end
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= x_in;
			y_q <= y_in;
			l_q <= '1;
		end else if (cnt_q != '0) begin
			x_q <= {x_q[qrk_pkg::HALF_BITS-2:0], nx};
			y_q <= {y_q[qrk_pkg::HALF_BITS-2:0], ny};
			l_q <= {l_q[0] ^ l_q[3], l_q[qrk_pkg::LFSR_BITS-1:1]};
		end
	end

	assign stat.done   = (cnt_q == '0);
	assign stat.active = (cnt_q != '0);
	assign x_out       = x_q;
	assign y_out       = y_q;

endmodule

`default_nettype wire

// ===== design/quark_permutation_136_unit.sv =====
// ---------------------------------------------------------------------------
// quark_permutation_136_unit: 136-bit sponge permutation
// Takes one state beat on din, runs 544 rounds, returns it on dout.
// ---------------------------------------------------------------------------
// Usage:
//   din carries a state (head, middle, tail); it is accepted when valid and
//   ready are both high. ready is high only while no state is in the round
//   engine. dout carries the permuted state from an output register.
// Sequence: the accept edge loads the engine, the rounds follow
//   (one round per cycle, set by the single-bit shift of the two feedback
//   registers), and once they finish and dout is free the result moves
//   into the output register, which raises dout.valid.
// Overlap: din is ready again the cycle after the result leaves the
//   engine, so a new state can be working while the previous one waits
//   on dout.
// Stall: if dout still holds an untaken result when rounds finish, the
//   engine holds its result and din stays low-ready until dout is free.
// Reset: arst_n clears the state machine, the round counter and dout.valid;
//   no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quark_permutation_136_unit (
	input wire logic  clk,
	input wire logic  arst_n,
	qrk_in_if.sink    din,
	qrk_out_if.source dout
);

	qrk_pkg::st_t        st_q;
	qrk_pkg::st_t        st_nxt;
	qrk_pkg::core_ctrl_t ctrl;
	qrk_pkg::core_stat_t stat;
	qrk_pkg::half_t      x_in;
	qrk_pkg::half_t      y_in;
	qrk_pkg::half_t      x_res;
	qrk_pkg::half_t      y_res;
	logic                in_acc;
	logic                out_free;
	logic                unload;
	logic                out_valid_q;

	logic [qrk_pkg::HEAD_W-1:0] head_q;
	logic [qrk_pkg::MID_W-1:0]  mid_q;
	logic [qrk_pkg::TAIL_W-1:0] tail_q;

	// MSB-first packing: X is head then high nibble, Y is low nibble then tail
	assign x_in = {din.state_head, din.state_middle[qrk_pkg::MID_W-1:qrk_pkg::NIB_W]};
	assign y_in = {din.state_middle[qrk_pkg::NIB_W-1:0], din.state_tail};

	assign in_acc   = din.valid && din.ready;
	assign out_free = !out_valid_q || dout.ready;

	qrk_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.x_in   (x_in),
		.y_in   (y_in),
		.stat   (stat),
		.x_out  (x_res),
		.y_out  (y_res)
	);

	// next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			qrk_pkg::ST_IDLE: begin
				if (din.valid) st_nxt = qrk_pkg::ST_RUN;
			end
			qrk_pkg::ST_RUN: begin
				if (stat.done && out_free) st_nxt = qrk_pkg::ST_IDLE;
			end
			default: st_nxt = qrk_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		din.ready = 1'b0;
		unload    = 1'b0;
		unique case (st_q)
			qrk_pkg::ST_IDLE: din.ready = 1'b1;
			qrk_pkg::ST_RUN:  unload    = stat.done && out_free;
			default: begin
				din.ready = 1'b0;
				unload    = 1'b0;
			end
		endcase
	end

	assign ctrl.load = in_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= qrk_pkg::ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (unload) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (unload) begin
			head_q <= x_res[qrk_pkg::HALF_BITS-1:qrk_pkg::NIB_W];
			mid_q  <= {x_res[qrk_pkg::NIB_W-1:0],
				y_res[qrk_pkg::HALF_BITS-1:qrk_pkg::TAIL_W]};
			tail_q <= y_res[qrk_pkg::TAIL_W-1:0];
		end
	end

	assign dout.valid           = out_valid_q;
	assign dout.permuted_head   = head_q;
	assign dout.permuted_middle = mid_q;
	assign dout.permuted_tail   = tail_q;

	// a beat is accepted only while the engine is empty
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (st_q == qrk_pkg::ST_IDLE) && stat.done)
		else $error("input beat accepted while rounds in progress");

	// an accepted beat starts a full round count
	a_acc_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> stat.active && (st_q == qrk_pkg::ST_RUN))
		else $error("round engine did not start after accept");

	// results only leave a finished engine
	a_unload_done: assert property (@(posedge clk) disable iff (!arst_n)
		unload |-> stat.done && !stat.active)
		else $error("result unloaded before rounds finished");

	// engine never runs without a state machine owning it
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == qrk_pkg::ST_IDLE) |-> stat.done)
		else $error("round engine active while idle");

endmodule

`default_nettype wire

// ===== verif/quark_permutation_136_unit_tb.sv =====
// ---------------------------------------------------------------------------
// quark_permutation_136_unit_tb: self-checking bench for the 136-bit permutation
// A table of directed states (zeros, ones, single bits at the register
// boundaries, byte patterns) is sent first, then about a thousand random
// states. Each accepted state is run through a local bit-serial model of
// the 544 rounds and the permuted state is compared field by field with
// what comes out on dout. Both channels idle in short random bursts; the
// sink is also held off long enough to stall the round engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module quark_permutation_136_unit_tb;

	localparam int          CLK_PERIOD  = 8;
	localparam int          RESET_CYC   = 12;
	localparam int          RAND_ITEMS  = 1000;
	localparam int          QUIET_ITEMS = 100;
	localparam int          SETTLE_CYC  = 600;
	localparam int          HOLD_CYC    = 1200;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int          DIR_N       = 19;

	// one full sponge state, laid out as on the channels
	typedef struct packed {
		logic [qrk_pkg::HEAD_W-1:0] head;
		logic [qrk_pkg::MID_W-1:0]  middle;
		logic [qrk_pkg::TAIL_W-1:0] tail;
	} sponge_state_t;

	logic clk = 1'b0;
	logic arst_n;

	qrk_in_if  din_ch ();
	qrk_out_if dout_ch ();

	quark_permutation_136_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	sponge_state_t expected_perm_q [$];
	int            mismatch_cnt = 0;
	int unsigned   cycle_cnt = 0;
	logic          src_idle = 1'b0;
	logic          snk_idle = 1'b0;
	int            hold_req_cnt = 0;

	// Directed states: {head, middle, tail}
	sponge_state_t directed_tbl [DIR_N] = '{
		136'h0000000000000000_00_0000000000000000,
		136'hFFFFFFFFFFFFFFFF_FF_FFFFFFFFFFFFFFFF,
		136'hFFFFFFFFFFFFFFFF_00_0000000000000000,
		136'h0000000000000000_FF_0000000000000000,
		136'h0000000000000000_00_FFFFFFFFFFFFFFFF,
		136'h8000000000000000_00_0000000000000000, // X[0]
		136'h0000000000000001_00_0000000000000000, // X[63]
		136'h0000000000000000_10_0000000000000000, // X[67]
		136'h0000000000000000_08_0000000000000000, // Y[0]
		136'h0000000000000000_00_8000000000000000, // Y[4]
		136'h0000000000000000_00_0000000000000001, // Y[67]
		136'hAAAAAAAAAAAAAAAA_55_AAAAAAAAAAAAAAAA,
		136'h5555555555555555_AA_5555555555555555,
		136'hFFFFFFFFFFFFFFFF_F0_0000000000000000, // X full, Y clear
		136'h0000000000000000_0F_FFFFFFFFFFFFFFFF, // X clear, Y full
		136'h0001020304050607_08_090A0B0C0D0E0F10,
		136'hFEDCBA9876543210_C3_0123456789ABCDEF,
		136'h0101010101010101_01_0101010101010101,
		136'h8080808080808080_80_8080808080808080
	};

	// Bit-serial permutation: stage k of each register sits at vector bit k
	function automatic sponge_state_t permute_state(input sponge_state_t s);
		logic [qrk_pkg::HALF_BITS-1:0] xs;
		logic [qrk_pkg::HALF_BITS-1:0] ys;
		logic [qrk_pkg::LFSR_BITS-1:0] ls;
		logic                          fx;
		logic                          fy;
		logic                          fl;
		logic                          h;
		sponge_state_t                 o;
		for (int k = 0; k < qrk_pkg::HEAD_W; k++) begin
			xs[k]     = s.head[qrk_pkg::HEAD_W-1-k];
			ys[4 + k] = s.tail[qrk_pkg::TAIL_W-1-k];
		end
		for (int k = 0; k < 4; k++) begin
			xs[64 + k] = s.middle[7-k];
			ys[k]      = s.middle[3-k];
		end
		ls = '1;
		for (int r = 0; r < qrk_pkg::ROUND_COUNT; r++) begin
			fx = xs[0] ^ ys[0] ^ xs[9] ^ xs[14] ^ xs[21] ^ xs[28] ^ xs[33] ^ xs[37] ^
				xs[45] ^ xs[52] ^ xs[55] ^ xs[50] ^
				(xs[59] & xs[55]) ^ (xs[37] & xs[33]) ^ (xs[15] & xs[9]) ^
				(xs[55] & xs[52] & xs[45]) ^ (xs[33] & xs[28] & xs[21]) ^
				(xs[59] & xs[45] & xs[28] & xs[9]) ^
				(xs[55] & xs[52] & xs[37] & xs[33]) ^
				(xs[59] & xs[55] & xs[21] & xs[15]) ^
				(xs[59] & xs[55] & xs[52] & xs[45] & xs[37]) ^
				(xs[33] & xs[28] & xs[21] & xs[15] & xs[9]) ^
				(xs[52] & xs[45] & xs[37] & xs[33] & xs[28] & xs[21]);
			fy = ys[0] ^ ys[7] ^ ys[16] ^ ys[20] ^ ys[30] ^ ys[35] ^ ys[37] ^ ys[42] ^
				ys[51] ^ ys[54] ^ ys[49] ^
				(ys[58] & ys[54]) ^ (ys[37] & ys[35]) ^ (ys[15] & ys[7]) ^
				(ys[54] & ys[51] & ys[42]) ^ (ys[35] & ys[30] & ys[20]) ^
				(ys[58] & ys[42] & ys[30] & ys[7]) ^
				(ys[54] & ys[51] & ys[37] & ys[35]) ^
				(ys[58] & ys[54] & ys[20] & ys[15]) ^
				(ys[58] & ys[54] & ys[51] & ys[42] & ys[37]) ^
				(ys[35] & ys[30] & ys[20] & ys[15] & ys[7]) ^
				(ys[51] & ys[42] & ys[37] & ys[35] & ys[30] & ys[20]);
			fl = ls[0] ^ ls[3];
			h = xs[25] ^ ys[59] ^ (ys[3] & xs[55]) ^ (xs[46] & xs[55]) ^
				(xs[55] & ys[59]) ^ (ys[3] & xs[25] & xs[46]) ^
				(ys[3] & xs[46] & xs[55]) ^ (ys[3] & xs[46] & ys[59]) ^
				(xs[25] & xs[46] & ys[59] & ls[0]) ^ (xs[25] & ls[0]) ^
				xs[1] ^ ys[2] ^ xs[4] ^ ys[10] ^ xs[31] ^ ys[43] ^ xs[56] ^ ls[0];
			// stage 0 leaves, feedback enters at the top stage
			xs = {fx ^ h, xs[qrk_pkg::HALF_BITS-1:1]};
			ys = {fy ^ h, ys[qrk_pkg::HALF_BITS-1:1]};
			ls = {fl, ls[qrk_pkg::LFSR_BITS-1:1]};
		end
		for (int k = 0; k < qrk_pkg::HEAD_W; k++) begin
			o.head[qrk_pkg::HEAD_W-1-k] = xs[k];
			o.tail[qrk_pkg::TAIL_W-1-k] = ys[4 + k];
		end
		for (int k = 0; k < 4; k++) begin
			o.middle[7-k] = xs[64 + k];
			o.middle[3-k] = ys[k];
		end
		return o;
	endfunction

	// Random state: mostly uniform, some sparse, dense or with an extreme middle byte
	function automatic sponge_state_t random_state();
		sponge_state_t s;
		int            nbits;
		s = {$urandom, $urandom, $urandom, $urandom, 8'($urandom)};
		nbits = $urandom_range(1, 3);
		case ($urandom_range(0, 9))
			0: begin
				s = '0;
				for (int k = 0; k < nbits; k++) s[$urandom_range(0, 135)] = 1'b1;
			end
			1: begin
				s = '1;
				for (int k = 0; k < nbits; k++) s[$urandom_range(0, 135)] = 1'b0;
			end
			2: begin
				s.middle = $urandom_range(0, 1) ? '1 : '0;
			end
			default: ;
		endcase
		return s;
	endfunction

	// Present one state and hold it until accepted; returns in the accept step
	task automatic send_state(input sponge_state_t s);
		int gap;
		gap = 0;
		if (src_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid        <= 1'b1;
		din_ch.state_head   <= s.head;
		din_ch.state_middle <= s.middle;
		din_ch.state_tail   <= s.tail;
		do @(posedge clk); while (din_ch.ready !== 1'b1);
		expected_perm_q.push_back(permute_state(s));
	endtask

	// Stop sending and wait for every outstanding permutation to come back
	task automatic await_drain();
		din_ch.valid <= 1'b0;
		while (expected_perm_q.size() != 0) @(posedge clk);
	endtask

	task automatic report_diff(input string fld, input logic [63:0] want,
		input logic [63:0] got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("[%0t] %s differs: expected %h, got %h", $time, fld, want, got);
		end
	endtask

	// Stimulus
	initial begin
		arst_n              <= 1'b0;
		din_ch.valid        <= 1'b0;
		din_ch.state_head   <= '0;
		din_ch.state_middle <= '0;
		din_ch.state_tail   <= '0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle = 1'b1;
		snk_idle = 1'b1;
		for (int i = 0; i < DIR_N; i++) send_state(directed_tbl[i]);
		await_drain();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// idling mode changes every 50 beats, none near the end
			if (n % 50 == 0) begin
				if (n >= RAND_ITEMS - QUIET_ITEMS) {src_idle, snk_idle} = 2'b00;
				else {src_idle, snk_idle} = 2'($urandom_range(0, 3));
			end
			if (n == RAND_ITEMS / 2) await_drain();
			// long sink hold-offs make the engine finish with dout still full
			if (n == 200 || n == 650) hold_req_cnt++;
			send_state(random_state());
		end
		await_drain();
		repeat (SETTLE_CYC) @(posedge clk);

		if (mismatch_cnt == 0 && expected_perm_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Sink: ready with random stall bursts and occasional long holds
	initial begin
		int stall_left;
		int hold_left;
		int hold_done;
		stall_left = 0;
		hold_left  = 0;
		hold_done  = 0;
		dout_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_done != hold_req_cnt) begin
				hold_done = hold_req_cnt;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				dout_ch.ready <= 1'b0;
			end else if (snk_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				dout_ch.ready <= 1'b0;
			end else begin
				dout_ch.ready <= 1'b1;
			end
		end
	end

	// Result check on every dout beat
	sponge_state_t want_s;
	always @(posedge clk) begin
		if (arst_n === 1'b1 && dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
			if (expected_perm_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10) begin
					$display("[%0t] unexpected beat on dout: %h %h %h", $time,
						dout_ch.permuted_head, dout_ch.permuted_middle,
						dout_ch.permuted_tail);
				end
			end else begin
				want_s = expected_perm_q.pop_front();
				if (dout_ch.permuted_head !== want_s.head)
					report_diff("permuted_head", want_s.head, dout_ch.permuted_head);
				if (dout_ch.permuted_middle !== want_s.middle)
					report_diff("permuted_middle", 64'(want_s.middle),
						64'(dout_ch.permuted_middle));
				if (dout_ch.permuted_tail !== want_s.tail)
					report_diff("permuted_tail", want_s.tail, dout_ch.permuted_tail);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
